/* hw/rtl/stepper_pulse_generator_macros.svh */
// ----------------------------------------------------------------------------
// stepper pulse generator assertion macros
// concurrent checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef STEPPER_PULSE_GENERATOR_MACROS_SVH
`define STEPPER_PULSE_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/spg_pkg.sv */
// ----------------------------------------------------------------------------
// spg_pkg
// shared types, codes and constants of the stepper pulse generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spg_pkg;

   // default parameter values
   localparam int DEFAULT_TIME_BITS  = 32;
   localparam int DEFAULT_COUNT_BITS = 20;

   // fixed field widths
   localparam int NOW_BITS       = 32;
   localparam int MODE_BITS      = 2;
   localparam int SPEED_BITS     = 19;
   localparam int STEPS_BITS     = 20;
   localparam int TANGLE_BITS    = 25;
   localparam int DPS_BITS       = 32;
   localparam int ANGLE_BITS     = 32;
   localparam int PERIOD_BITS    = 20;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int REQ_DATA_BITS  = 32;
   localparam int RSP_DATA_BITS  = 64;

   // product bits below the Q16.16 point, with the factor of two folded in
   localparam int FRAC_DROP_BITS = 15;

   localparam logic [PERIOD_BITS-1:0] US_PER_S = 20'd1000000;

   // register reset values
   localparam logic                  RESET_ENABLE       = 1'b1;
   localparam logic [SPEED_BITS-1:0] RESET_SPEED_HZ     = 19'd1500;
   localparam logic [DPS_BITS-1:0]   RESET_DEG_PER_STEP = 32'd1717987;

   // run modes
   localparam logic [MODE_BITS-1:0] MODE_DONE     = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CONSTANT = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_STEPS    = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_ANGLE    = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_ENABLE       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIR_SELECT   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RUN_MODE     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPEED_HZ     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TARGET_STEPS = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TARGET_ANGLE = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEG_PER_STEP = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_PERIOD,
      ST_COMPARE,
      ST_MULT,
      ST_DIV,
      ST_UPDATE,
      ST_FINISH
   } spg_state_type;

   // control of the shared serial divider
   typedef struct packed {
      logic clear;
      logic step;
      logic num_bit;
   } spg_div_ctrl_type;

endpackage

/* hw/rtl/stepper_pulse_generator.sv */
// ----------------------------------------------------------------------------
// stepper_pulse_generator
// step/direction pulse generator advanced by microsecond timestamp ticks
// ----------------------------------------------------------------------------
// Each transfer on req_ carries the current time in microseconds and yields
// exactly one transfer on rsp_ with the step pin level, the enable and
// direction copies, the active mode and the step and angle counters as they
// stand after the tick. One tick is worked on at a time. The first running
// tick after reset or after a speed_hz write also runs the serial period
// division 1000000/speed_hz. A tick that toggles the pin also runs the
// bit-serial shift-add multiplier (elapsed * deg_per_step) and the bit-serial
// divider that scales the product by the period. A finished result waits in
// the output register while the next tick is accepted. Configuration writes
// are taken every cycle on the csr_ port.
`timescale 1ns / 1ps

`include "stepper_pulse_generator_macros.svh"

module stepper_pulse_generator
   import spg_pkg::*;
#(
   parameter int TIME_BITS  = DEFAULT_TIME_BITS,
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   // tick input, tdata: now_us[31:0]
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   // result output, tdata: pulse_level[0], enable_out[1], direction_out[2],
   // mode_now[4:3], steps_done[24:5], angle_done[56:25], zero fill[63:57]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // register write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int PROD_BITS    = TIME_BITS + DPS_BITS;
   localparam int NUM_BITS     = PROD_BITS - FRAC_DROP_BITS;
   localparam int ITER_BITS    = $clog2(NUM_BITS + 1);
   localparam int WIDE_BITS    = (TIME_BITS > NOW_BITS) ? TIME_BITS : NOW_BITS;
   localparam int CMP_T_BITS   = (TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS;
   localparam int CNT_CMP_BITS = (COUNT_BITS > STEPS_BITS) ? COUNT_BITS : STEPS_BITS;
   localparam int RSP_FILL     = RSP_DATA_BITS - 3 - MODE_BITS - STEPS_BITS - ANGLE_BITS;

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------

   spg_state_type state_ff, state_in;

   // configuration
   logic                   enable_ff, enable_in;
   logic                   dir_ff, dir_in;
   logic [SPEED_BITS-1:0]  speed_ff, speed_in;
   logic [STEPS_BITS-1:0]  tsteps_ff, tsteps_in;
   logic [TANGLE_BITS-1:0] tangle_ff, tangle_in;
   logic [DPS_BITS-1:0]    dps_ff, dps_in;

   // generator state
   logic [MODE_BITS-1:0]   mode_ff, mode_in;
   logic                   pulse_ff, pulse_in;
   logic                   pin_ff, pin_in;
   logic [TIME_BITS-1:0]   last_ff, last_in;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [ANGLE_BITS-1:0]  angle_ff, angle_in;
   logic                   pvalid_ff, pvalid_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;

   // per-tick working registers
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [TIME_BITS-1:0]   elapsed_ff, elapsed_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [ITER_BITS-1:0]   iter_ff, iter_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_pulse_ff, rsp_pulse_in;
   logic                   rsp_enable_ff, rsp_enable_in;
   logic                   rsp_dir_ff, rsp_dir_in;
   logic [MODE_BITS-1:0]   rsp_mode_ff, rsp_mode_in;
   logic [STEPS_BITS-1:0]  rsp_steps_ff, rsp_steps_in;
   logic [ANGLE_BITS-1:0]  rsp_angle_ff, rsp_angle_in;

   // ------------------------------------------------------------------------
   // combinational helpers
   // ------------------------------------------------------------------------

   logic                    req_accept;
   logic                    rsp_load;
   logic [WIDE_BITS-1:0]    now_wide;
   logic [TIME_BITS-1:0]    now_time;
   logic                    steps_ok;
   logic                    angle_ok;
   logic                    run_ok;
   logic                    limit_hit;
   logic [SPEED_BITS-1:0]   speed_eff;
   logic [PERIOD_BITS-1:0]  period_now;
   logic [PERIOD_BITS-1:0]  half_period;
   logic                    toggle_due;
   logic [TIME_BITS:0]      mult_sum;
   logic [ANGLE_BITS-1:0]   angle_inc;
   logic [ANGLE_BITS:0]     angle_sum;
   logic                    pulse_next;
   logic [CNT_CMP_BITS-1:0] cnt_wide;
   logic                    iter_last;

   spg_div_ctrl_type        div_ctrl;
   logic [PERIOD_BITS-1:0]  div_divisor;
   logic [ANGLE_BITS-1:0]   div_quotient;
   logic                    div_overflow;

   assign csr_ready  = 1'b1;
   assign req_accept = req_tvalid && req_tready;

   // time masked to TIME_BITS, zero-extended when wider than the input
   assign now_wide = WIDE_BITS'(req_tdata[NOW_BITS-1:0]);
   assign now_time = now_wide[TIME_BITS-1:0];

   // mode limits, checked before any pulse work
   assign steps_ok  = CNT_CMP_BITS'(cnt_ff) <= CNT_CMP_BITS'(tsteps_ff);
   assign angle_ok  = angle_ff <= ANGLE_BITS'(tangle_ff);
   assign run_ok    = (mode_ff == MODE_CONSTANT) ||
                      ((mode_ff == MODE_STEPS) && steps_ok) ||
                      ((mode_ff == MODE_ANGLE) && angle_ok);
   assign limit_hit = ((mode_ff == MODE_STEPS) && !steps_ok) ||
                      ((mode_ff == MODE_ANGLE) && !angle_ok);

   // zero speed runs as 1 Hz
   assign speed_eff = (speed_ff == '0) ? SPEED_BITS'(1) : speed_ff;

   // freshly divided period is still in the divider during the compare cycle
   assign period_now  = pvalid_ff ? period_ff : div_quotient[PERIOD_BITS-1:0];
   assign half_period = period_now >> 1;
   assign toggle_due  = CMP_T_BITS'(elapsed_ff) >= CMP_T_BITS'(half_period);

   // shift-add multiplier step, product builds up in prod_ff
   assign mult_sum = {1'b0, prod_ff[PROD_BITS-1:DPS_BITS]} +
                     (prod_ff[0] ? {1'b0, elapsed_ff} : '0);

   // swept angle for this toggle, saturating accumulate
   assign angle_inc  = div_overflow ? '1 : div_quotient;
   assign angle_sum  = {1'b0, angle_ff} + {1'b0, angle_inc};
   assign pulse_next = ~pulse_ff;

   assign cnt_wide  = CNT_CMP_BITS'(cnt_ff);
   assign iter_last = (iter_ff == '0);

   // divider runs on the speed first, then on the cached period
   assign div_divisor = (state_ff == ST_PERIOD) ? PERIOD_BITS'(speed_eff) : period_ff;

   spg_serial_div #(
      .DIV_BITS (PERIOD_BITS),
      .QUO_BITS (ANGLE_BITS)
   ) u_div (
      .clock    (clock),
      .div_ctrl (div_ctrl),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .overflow (div_overflow)
   );

   // ------------------------------------------------------------------------
   // state machine: next state
   // ------------------------------------------------------------------------

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (enable_ff && run_ok) begin
               state_in = pvalid_ff ? ST_COMPARE : ST_PERIOD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_PERIOD: begin
            if (iter_last) state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            state_in = toggle_due ? ST_MULT : ST_FINISH;
         end
         ST_MULT: begin
            if (iter_last) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (iter_last) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // state machine: outputs
   // ------------------------------------------------------------------------

   always_comb begin
      req_tready       = 1'b0;
      rsp_load         = 1'b0;
      div_ctrl.clear   = 1'b0;
      div_ctrl.step    = 1'b0;
      div_ctrl.num_bit = prod_ff[PROD_BITS-1];
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_DECIDE: begin
            div_ctrl.clear = 1'b1;
         end
         ST_PERIOD: begin
            div_ctrl.step = 1'b1;
         end
         ST_COMPARE: begin
            div_ctrl.clear = 1'b1;
         end
         ST_DIV: begin
            div_ctrl.step = 1'b1;
         end
         ST_FINISH: begin
            // output register free or emptying this cycle
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // datapath and register file
   // ------------------------------------------------------------------------

   always_comb begin
      enable_in     = enable_ff;
      dir_in        = dir_ff;
      speed_in      = speed_ff;
      tsteps_in     = tsteps_ff;
      tangle_in     = tangle_ff;
      dps_in        = dps_ff;
      mode_in       = mode_ff;
      pulse_in      = pulse_ff;
      pin_in        = pin_ff;
      last_in       = last_ff;
      cnt_in        = cnt_ff;
      angle_in      = angle_ff;
      pvalid_in     = pvalid_ff;
      period_in     = period_ff;
      now_in        = now_ff;
      elapsed_in    = elapsed_ff;
      prod_in       = prod_ff;
      iter_in       = iter_ff;
      rsp_pulse_in  = rsp_pulse_ff;
      rsp_enable_in = rsp_enable_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_mode_in   = rsp_mode_ff;
      rsp_steps_in  = rsp_steps_ff;
      rsp_angle_in  = rsp_angle_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) now_in = now_time;
         end
         ST_DECIDE: begin
            // wrapping time since the last toggle
            elapsed_in = now_ff - last_ff;
            if (!enable_ff) begin
               // disabled: pin low, everything else holds
               pin_in = 1'b0;
            end else if (limit_hit) begin
               // run finished: no pulse, back to done
               cnt_in   = '0;
               angle_in = '0;
               mode_in  = MODE_DONE;
            end else if (run_ok && !pvalid_ff) begin
               // numerator 1000000 shifts out of the top of prod_ff
               prod_in = {US_PER_S, (PROD_BITS - PERIOD_BITS)'(0)};
               iter_in = ITER_BITS'(PERIOD_BITS - 1);
            end
         end
         ST_PERIOD: begin
            prod_in = prod_ff << 1;
            iter_in = iter_ff - ITER_BITS'(1);
         end
         ST_COMPARE: begin
            if (!pvalid_ff) begin
               period_in = div_quotient[PERIOD_BITS-1:0];
               pvalid_in = 1'b1;
            end
            if (toggle_due) begin
               prod_in = PROD_BITS'(dps_ff);
               iter_in = ITER_BITS'(DPS_BITS - 1);
            end else begin
               pin_in = pulse_ff;
            end
         end
         ST_MULT: begin
            prod_in = {mult_sum, prod_ff[DPS_BITS-1:1]};
            iter_in = iter_last ? ITER_BITS'(NUM_BITS - 1) : iter_ff - ITER_BITS'(1);
         end
         ST_DIV: begin
            // product bits from the top down, low fraction bits never enter
            prod_in = prod_ff << 1;
            iter_in = iter_ff - ITER_BITS'(1);
         end
         ST_UPDATE: begin
            pulse_in = pulse_next;
            pin_in   = pulse_next;
            last_in  = now_ff;
            angle_in = angle_sum[ANGLE_BITS] ? '1 : angle_sum[ANGLE_BITS-1:0];
            // rising edge counts a step, saturating
            if (pulse_next && (cnt_ff != '1)) cnt_in = cnt_ff + COUNT_BITS'(1);
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_pulse_in  = pin_ff;
               rsp_enable_in = enable_ff;
               rsp_dir_in    = dir_ff;
               rsp_mode_in   = mode_ff;
               rsp_steps_in  = cnt_wide[STEPS_BITS-1:0];
               rsp_angle_in  = angle_ff;
            end
         end
         default: begin
            iter_in = iter_ff;
         end
      endcase

      // register writes: the user must write only while no tick is in flight; the block does not enforce it
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ENABLE: begin
               enable_in = csr_data[0];
            end
            REG_DIR_SELECT: begin
               cnt_in   = '0;
               angle_in = '0;
               dir_in   = csr_data[0];
               mode_in  = MODE_DONE;
            end
            REG_RUN_MODE: begin
               cnt_in   = '0;
               angle_in = '0;
               mode_in  = csr_data[MODE_BITS-1:0];
            end
            REG_SPEED_HZ: begin
               speed_in  = csr_data[SPEED_BITS-1:0];
               pvalid_in = 1'b0;
            end
            REG_TARGET_STEPS: begin
               tsteps_in = csr_data[STEPS_BITS-1:0];
            end
            REG_TARGET_ANGLE: begin
               tangle_in = csr_data[TANGLE_BITS-1:0];
            end
            REG_DEG_PER_STEP: begin
               dps_in = csr_data[DPS_BITS-1:0];
            end
            default: begin
               // unused index, ignored
               dps_in = dps_ff;
            end
         endcase
      end
   end

   // output valid: set on load, cleared once the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= RESET_ENABLE;
         dir_ff       <= 1'b0;
         speed_ff     <= RESET_SPEED_HZ;
         tsteps_ff    <= '0;
         tangle_ff    <= '0;
         dps_ff       <= RESET_DEG_PER_STEP;
         mode_ff      <= MODE_DONE;
         pulse_ff     <= 1'b0;
         pin_ff       <= 1'b0;
         last_ff      <= '0;
         cnt_ff       <= '0;
         angle_ff     <= '0;
         pvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         dir_ff       <= dir_in;
         speed_ff     <= speed_in;
         tsteps_ff    <= tsteps_in;
         tangle_ff    <= tangle_in;
         dps_ff       <= dps_in;
         mode_ff      <= mode_in;
         pulse_ff     <= pulse_in;
         pin_ff       <= pin_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         angle_ff     <= angle_in;
         pvalid_ff    <= pvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and output payload registers
   always_ff @(posedge clock) begin
      period_ff     <= period_in;
      now_ff        <= now_in;
      elapsed_ff    <= elapsed_in;
      prod_ff       <= prod_in;
      iter_ff       <= iter_in;
      rsp_pulse_ff  <= rsp_pulse_in;
      rsp_enable_ff <= rsp_enable_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_mode_ff   <= rsp_mode_in;
      rsp_steps_ff  <= rsp_steps_in;
      rsp_angle_ff  <= rsp_angle_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_FILL{1'b0}}, rsp_angle_ff, rsp_steps_ff, rsp_mode_ff,
                        rsp_dir_ff, rsp_enable_ff, rsp_pulse_ff};

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // done mode between ticks always has cleared counters
   `ASSERT_IMPLIES(a_done_clear, clock, reset, (state_ff == ST_IDLE) && (mode_ff == MODE_DONE), (cnt_ff == '0) && (angle_ff == '0))

   // a speed write forces the period to be divided again
   `ASSERT_NEXT(a_speed_stale, clock, reset, csr_valid && (csr_index == REG_SPEED_HZ), !pvalid_ff)

   // loading a result ends the tick and shows it on the port
   `ASSERT_NEXT(a_result_loaded, clock, reset, rsp_load, rsp_valid_ff && (state_ff == ST_IDLE))

   // an accepted tick goes straight to the mode decision
   `ASSERT_NEXT(a_accept_decide, clock, reset, req_tvalid && req_tready, state_ff == ST_DECIDE)

endmodule

/* hw/rtl/spg_serial_div.sv */
// ----------------------------------------------------------------------------
// spg_serial_div
// restoring divider, one numerator bit per step, sticky quotient overflow
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spg_serial_div
   import spg_pkg::*;
#(
   parameter int DIV_BITS = PERIOD_BITS,
   parameter int QUO_BITS = ANGLE_BITS
) (
   input  logic                clock,
   input  spg_div_ctrl_type    div_ctrl,
   input  logic [DIV_BITS-1:0] divisor,
   output logic [QUO_BITS-1:0] quotient,
   output logic                overflow
);

   logic [DIV_BITS-1:0] rem_ff, rem_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic                ovf_ff, ovf_in;
   logic [DIV_BITS:0]   rem_shift;
   logic [DIV_BITS:0]   rem_diff;
   logic                fits;

   assign rem_shift = {rem_ff, div_ctrl.num_bit};
   assign fits      = rem_shift >= {1'b0, divisor};
   assign rem_diff  = rem_shift - {1'b0, divisor};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      if (div_ctrl.clear) begin
         rem_in = '0;
         quo_in = '0;
         ovf_in = 1'b0;
      end else if (div_ctrl.step) begin
         rem_in = fits ? rem_diff[DIV_BITS-1:0] : rem_shift[DIV_BITS-1:0];
         quo_in = {quo_ff[QUO_BITS-2:0], fits};
         // a set bit leaving the top means the quotient no longer fits
         ovf_in = ovf_ff | quo_ff[QUO_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign quotient = quo_ff;
   assign overflow = ovf_ff;

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stepper step/direction pulse generator
// ----------------------------------------------------------------------------
// Timestamp ticks go in on req_ and one status word comes back per tick on
// rsp_. A behavioral copy of the pin, mode, step and angle state predicts every
// status word when its tick is accepted, and each returned word is checked
// field by field against the oldest prediction. Register writes on csr_ go in
// only when every tick has come back. A short directed run covers the
// reset state, each run mode, the speed extremes, time wrap, angle saturation,
// disable and direction writes, the unused index and one long output hold-off.
// Then come random phases of settings and ticks, with random gaps on both sides.
`timescale 1ns / 1ps

module tb;
   import spg_pkg::*;

   // csr index that has no register behind it
   localparam logic [CSR_INDEX_BITS-1:0] REG_NONE = 3'd7;

   localparam int HOLD_CYCLES   = 600;
   localparam int DRAIN_CYCLES  = 150;
   localparam int RANDOM_TICKS  = 1200;
   localparam int REPORT_LINES  = 100;
   localparam logic [TANGLE_BITS-1:0] ANGLE_LIMIT = 25'd23592960;

   // rsp_tdata layout, lowest bit last
   typedef struct packed {
      logic [6:0]             fill;
      logic [ANGLE_BITS-1:0]  angle;
      logic [STEPS_BITS-1:0]  steps;
      logic [MODE_BITS-1:0]   mode;
      logic                   direction;
      logic                   enable;
      logic                   pulse;
   } status_word_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;

   stepper_pulse_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // behavioral copy of the registers and the pulse state
   // ---------------------------------------------------------------------------
   logic                   cfg_enable        = RESET_ENABLE;
   logic                   cfg_dir           = 1'b0;
   logic [MODE_BITS-1:0]   cfg_run_mode      = MODE_DONE;
   logic [SPEED_BITS-1:0]  cfg_speed         = RESET_SPEED_HZ;
   logic [STEPS_BITS-1:0]  cfg_target_steps  = '0;
   logic [TANGLE_BITS-1:0] cfg_target_angle  = '0;
   logic [DPS_BITS-1:0]    cfg_dps           = RESET_DEG_PER_STEP;

   logic [MODE_BITS-1:0]   mode_st    = MODE_DONE;
   logic                   pulse_st   = 1'b0;
   logic                   pin_level  = 1'b0;
   logic [NOW_BITS-1:0]    last_toggle = '0;
   logic [STEPS_BITS-1:0]  step_count = '0;
   logic [ANGLE_BITS-1:0]  angle_acc  = '0;

   // status words predicted for accepted ticks, oldest first
   status_word_type status_due[$];

   int  mismatches   = 0;
   int  ticks_sent   = 0;
   int  words_seen   = 0;
   bit  sender_eager = 1'b0;
   bit  rsp_hold_req = 1'b0;
   logic [NOW_BITS-1:0] clock_us = '0;

   // full step period in microseconds, a speed of zero runs as 1 Hz
   function automatic logic [PERIOD_BITS-1:0] period_us();
      logic [SPEED_BITS-1:0] hz;
      hz = (cfg_speed == '0) ? SPEED_BITS'(1) : cfg_speed;
      return US_PER_S / hz;
   endfunction

   // advance the pulse state by one accepted tick and queue its status word
   task automatic predict_status(input logic [NOW_BITS-1:0] now);
      logic [PERIOD_BITS-1:0] period;
      logic [NOW_BITS-1:0]    elapsed;
      logic [95:0]            quotient;
      logic [ANGLE_BITS-1:0]  gain;
      logic                   running;
      status_word_type        word;
      running = 1'b0;
      if (!cfg_enable) begin
         // pin forced low, pulse state and counters held
         pin_level = 1'b0;
      end else begin
         case (mode_st)
            MODE_CONSTANT: begin
               running = 1'b1;
            end
            MODE_STEPS: begin
               if (step_count <= cfg_target_steps) begin
                  running = 1'b1;
               end else begin
                  mode_st    = MODE_DONE;
                  step_count = '0;
                  angle_acc  = '0;
               end
            end
            MODE_ANGLE: begin
               if (angle_acc <= {7'd0, cfg_target_angle}) begin
                  running = 1'b1;
               end else begin
                  mode_st    = MODE_DONE;
                  step_count = '0;
                  angle_acc  = '0;
               end
            end
            default: begin
            end
         endcase
      end
      if (running) begin
         period  = period_us();
         elapsed = now - last_toggle;
         if (elapsed >= {12'd0, period >> 1}) begin
            // swept angle in Q16.16: 2 * elapsed * dps / (period * 2^16)
            quotient = (({64'd0, elapsed} * {64'd0, cfg_dps}) << 1) / ({76'd0, period} << 16);
            gain     = (quotient > 96'hFFFF_FFFF) ? '1 : quotient[31:0];
            pulse_st = !pulse_st;
            angle_acc = (angle_acc > ~gain) ? '1 : angle_acc + gain;
            if (pulse_st && step_count != '1) begin
               step_count = step_count + 1'b1;
            end
            last_toggle = now;
         end
         pin_level = pulse_st;
      end
      word           = '0;
      word.pulse     = pin_level;
      word.enable    = cfg_enable;
      word.direction = cfg_dir;
      word.mode      = mode_st;
      word.steps     = step_count;
      word.angle     = angle_acc;
      status_due.push_back(word);
   endtask

   // ---------------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------------
   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 16);
      return $urandom_range(30, 120);
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < REPORT_LINES) begin
         $display("%0t ns: status word %0d: %s", $time, words_seen, msg);
      end
      mismatches++;
   endtask

   // one tick transfer; req_tvalid stays high when the next tick follows at once
   task automatic send_tick(input logic [NOW_BITS-1:0] now);
      int gap;
      gap = sender_eager ? 0 : idle_cycles();
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= now;
      do @(posedge clock); while (!req_tready);
      predict_status(now);
      ticks_sent++;
   endtask

   task automatic tick_after(input logic [NOW_BITS-1:0] delta);
      clock_us = clock_us + delta;
      send_tick(clock_us);
   endtask

   // register write, issued only once every tick has returned its status
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0]  data);
      req_tvalid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_ENABLE: begin
            cfg_enable = data[0];
         end
         REG_DIR_SELECT: begin
            cfg_dir    = data[0];
            mode_st    = MODE_DONE;
            step_count = '0;
            angle_acc  = '0;
         end
         REG_RUN_MODE: begin
            cfg_run_mode = data[MODE_BITS-1:0];
            mode_st      = data[MODE_BITS-1:0];
            step_count   = '0;
            angle_acc    = '0;
         end
         REG_SPEED_HZ:     cfg_speed        = data[SPEED_BITS-1:0];
         REG_TARGET_STEPS: cfg_target_steps = data[STEPS_BITS-1:0];
         REG_TARGET_ANGLE: cfg_target_angle = data[TANGLE_BITS-1:0];
         REG_DEG_PER_STEP: cfg_dps          = data;
         default: begin
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // result side: random stalls, plus one long hold-off on request
   // ---------------------------------------------------------------------------
   initial begin : rsp_stall
      int n;
      int burst;
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            for (n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
         end else begin
            n = idle_cycles();
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            // now and then a long stretch with no stall at all
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 6);
            repeat (burst) @(posedge clock);
         end
      end
   end

   // every accepted status word is checked against the oldest prediction
   status_word_type got_word;
   status_word_type want_word;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_word = rsp_tdata;
         if (status_due.size() == 0) begin
            report_mismatch($sformatf("word %h arrived with no tick waiting", rsp_tdata));
         end else begin
            want_word = status_due.pop_front();
            if (got_word.pulse !== want_word.pulse)
               report_mismatch($sformatf("pulse_level got %0d want %0d",
                                         got_word.pulse, want_word.pulse));
            if (got_word.enable !== want_word.enable)
               report_mismatch($sformatf("enable_out got %0d want %0d",
                                         got_word.enable, want_word.enable));
            if (got_word.direction !== want_word.direction)
               report_mismatch($sformatf("direction_out got %0d want %0d",
                                         got_word.direction, want_word.direction));
            if (got_word.mode !== want_word.mode)
               report_mismatch($sformatf("mode_now got %0d want %0d",
                                         got_word.mode, want_word.mode));
            if (got_word.steps !== want_word.steps)
               report_mismatch($sformatf("steps_done got %0d want %0d",
                                         got_word.steps, want_word.steps));
            if (got_word.angle !== want_word.angle)
               report_mismatch($sformatf("angle_done got %h want %h",
                                         got_word.angle, want_word.angle));
            if (got_word.fill !== want_word.fill)
               report_mismatch($sformatf("zero fill got %h", got_word.fill));
         end
         words_seen++;
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------
   // out of reset the mode is done, so ticks move nothing
   task automatic test_after_reset();
      send_tick(32'd0);
      send_tick(32'hFFFF_FFFF);
   endtask

   // default 1500 Hz: half period 333 us, then a toggle across the time wrap
   task automatic test_constant_run();
      write_reg(REG_RUN_MODE, MODE_CONSTANT);
      clock_us = '0;
      tick_after(32'd100);
      tick_after(32'd233);
      tick_after(32'd0);
      tick_after(32'd333);
      clock_us = 32'hFFFF_FF00;
      tick_after(32'd0);
      tick_after(32'h200);
   endtask

   // half period of zero toggles every tick; huge jumps saturate the angle;
   // a speed of zero runs as 1 Hz
   task automatic test_speed_extremes();
      write_reg(REG_SPEED_HZ, 32'h7FFFF);
      write_reg(REG_DEG_PER_STEP, 32'hFFFF_FFFF);
      tick_after(32'd0);
      tick_after(32'hF000_0000);
      tick_after(32'h1000_0000);
      write_reg(REG_SPEED_HZ, 32'd0);
      write_reg(REG_DEG_PER_STEP, 32'd1);
      write_reg(REG_RUN_MODE, MODE_CONSTANT);
      tick_after(32'd499_999);
      tick_after(32'd1);
      write_reg(REG_SPEED_HZ, 32'd500_000);
      write_reg(REG_DEG_PER_STEP, RESET_DEG_PER_STEP);
      tick_after(32'd1);
   endtask

   // steps mode runs while the count is at or below the target, then stops
   task automatic test_step_target();
      int k;
      write_reg(REG_SPEED_HZ, RESET_SPEED_HZ);
      write_reg(REG_TARGET_STEPS, 32'd1);
      write_reg(REG_RUN_MODE, MODE_STEPS);
      for (k = 0; k < 8 && mode_st == MODE_STEPS; k++) begin
         tick_after(period_us() >> 1);
      end
      tick_after(period_us() >> 1);
      // a target at the count ceiling never finishes
      write_reg(REG_TARGET_STEPS, 32'hF_FFFF);
      write_reg(REG_RUN_MODE, MODE_STEPS);
      tick_after(period_us() >> 1);
   endtask

   // angle mode with a zero target stops after the first swept angle
   task automatic test_angle_target();
      write_reg(REG_TARGET_ANGLE, 32'd0);
      write_reg(REG_RUN_MODE, MODE_ANGLE);
      tick_after(period_us() >> 1);
      tick_after(period_us() >> 1);
      write_reg(REG_TARGET_ANGLE, ANGLE_LIMIT);
      write_reg(REG_DEG_PER_STEP, 32'hFFFF_FFFF);
      write_reg(REG_RUN_MODE, MODE_ANGLE);
      tick_after(period_us() >> 1);
      tick_after(period_us() >> 1);
   endtask

   // disabled: pin low, pulse state and counters held
   task automatic test_disable();
      write_reg(REG_DEG_PER_STEP, RESET_DEG_PER_STEP);
      write_reg(REG_RUN_MODE, MODE_CONSTANT);
      tick_after(period_us() >> 1);
      write_reg(REG_ENABLE, 32'd0);
      tick_after(period_us() >> 1);
      write_reg(REG_ENABLE, 32'd1);
      tick_after(period_us() >> 1);
   endtask

   // a direction write clears the counters and ends the run
   task automatic test_direction();
      write_reg(REG_DIR_SELECT, 32'd1);
      tick_after(period_us() >> 1);
      write_reg(REG_DIR_SELECT, 32'd0);
      write_reg(REG_RUN_MODE, MODE_CONSTANT);
      tick_after(period_us() >> 1);
   endtask

   // the spare index changes nothing
   task automatic test_unused_index();
      write_reg(REG_NONE, 32'hFFFF_FFFF);
      tick_after(period_us() >> 1);
   endtask

   // output held off for a long stretch while ticks keep coming
   task automatic test_output_backpressure();
      int k;
      write_reg(REG_RUN_MODE, MODE_CONSTANT);
      rsp_hold_req = 1'b1;
      wait (rsp_hold_req == 1'b0);
      sender_eager = 1'b1;
      for (k = 0; k < 12; k++) begin
         tick_after((k % 3 == 0) ? 32'd1 : {12'd0, period_us() >> 1});
      end
      sender_eager = 1'b0;
   endtask

   // random phases: new settings, re-armed mode, then a run of ticks
   task automatic test_random_traffic();
      int                     first_tick;
      int                     phase_len;
      int                     r;
      int                     k;
      logic [SPEED_BITS-1:0]  speed;
      logic [DPS_BITS-1:0]    dps;
      logic [31:0]            angle_goal;
      logic [MODE_BITS-1:0]   mode_pick;
      logic [NOW_BITS-1:0]    half;
      logic [NOW_BITS-1:0]    delta;
      first_tick = ticks_sent;
      while (ticks_sent < first_tick + RANDOM_TICKS) begin
         write_reg(REG_ENABLE, ($urandom_range(0, 9) != 0));
         if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_DIR_SELECT, $urandom_range(0, 1));
         end
         case ($urandom_range(0, 5))
            0: speed = RESET_SPEED_HZ;
            1: speed = $urandom_range(1, 200);
            2: speed = $urandom_range(1, 500_000);
            3: speed = $urandom_range(20_000, 524_287);
            4: begin
               r = $urandom_range(0, 2);
               speed = (r == 0) ? 19'd0 : (r == 1) ? 19'd500_000 : 19'h7FFFF;
            end
            default: speed = $urandom_range(500, 5000);
         endcase
         write_reg(REG_SPEED_HZ, speed);
         case ($urandom_range(0, 4))
            0: dps = RESET_DEG_PER_STEP;
            1: dps = $urandom_range(1, 1000);
            2: dps = 32'hFFFF_FFFF;
            default: dps = $urandom;
         endcase
         write_reg(REG_DEG_PER_STEP, dps);
         // targets mostly small enough that the run finishes within a phase
         r = $urandom_range(0, 9);
         write_reg(REG_TARGET_STEPS, (r < 6) ? $urandom_range(0, 24) :
                                     (r < 8) ? $urandom_range(0, 20'hF_FFFF) : 32'hF_FFFF);
         r = $urandom_range(0, 9);
         if (r < 6) begin
            angle_goal = $urandom_range(0, 40) * (dps >> 16);
            if (angle_goal > ANGLE_LIMIT) angle_goal = ANGLE_LIMIT;
         end else if (r < 8) begin
            angle_goal = $urandom_range(0, ANGLE_LIMIT);
         end else begin
            angle_goal = $urandom_range(0, 25'h1FF_FFFF);
         end
         write_reg(REG_TARGET_ANGLE, angle_goal);
         r = $urandom_range(0, 99);
         mode_pick = (r < 10) ? MODE_DONE : (r < 40) ? MODE_CONSTANT :
                     (r < 70) ? MODE_STEPS : MODE_ANGLE;
         write_reg(REG_RUN_MODE, mode_pick);

         sender_eager = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(20, 70);
         for (k = 0; k < phase_len; k++) begin
            half = {12'd0, period_us() >> 1};
            r = $urandom_range(0, 99);
            if (r < 50) begin
               delta = half + $urandom_range(0, half / 4 + 1);
            end else if (r < 70) begin
               delta = $urandom_range(0, half);
            end else if (r < 78) begin
               delta = '0;
            end else if (r < 88) begin
               delta = $urandom;
            end else if (r < 94) begin
               // fresh random time base
               clock_us = $urandom;
               delta = '0;
            end else begin
               delta = half * $urandom_range(2, 6);
            end
            tick_after(delta);
         end
      end
      sender_eager = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_after_reset();
      test_constant_run();
      test_speed_extremes();
      test_step_target();
      test_angle_target();
      test_disable();
      test_direction();
      test_unused_index();
      test_output_backpressure();
      test_random_traffic();
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // run limit, well above the slowest correct run
   initial begin
      #60_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
